// ===== rtl/core/rcafa_pkg.sv =====
// package for the rc / autonomy failsafe arbiter
// holds codes, item and state types and reset values; no dependencies

package rcafa_pkg;

  localparam int unsigned TimeW = 32;
  localparam int unsigned CntW  = 8;
  localparam int unsigned CfgW  = 32;
  localparam int unsigned IdxW  = 2;

  typedef enum logic [2:0] {
    OP_TICK    = 3'd0,
    OP_RC      = 3'd1,
    OP_CMD     = 3'd2,
    OP_ARM     = 3'd3,
    OP_DISARM  = 3'd4,
    OP_REQ_ARM = 3'd5
  } op_e;

  typedef enum logic [2:0] {
    ST_OFF  = 3'd0,
    ST_ARM  = 3'd1,
    ST_AUTO = 3'd2,
    ST_RC   = 3'd3,
    ST_KILL = 3'd4
  } st_e;

  typedef enum logic [1:0] {
    SRC_NONE = 2'd0,
    SRC_RC   = 2'd1,
    SRC_CMD  = 2'd2,
    SRC_KILL = 2'd3
  } src_e;

  typedef enum logic [1:0] {
    ARM_KEEP   = 2'd0,
    ARM_FORCE0 = 2'd1,
    ARM_FORCE1 = 2'd2
  } arm_e;

  typedef enum logic [1:0] {
    MODE_KEEP = 2'd0,
    MODE_ATT  = 2'd1,
    MODE_RATE = 2'd2
  } mode_e;

  typedef enum logic [IdxW-1:0] {
    REG_RC_TIMEOUT = 2'd0,
    REG_MIN_SEND   = 2'd1,
    REG_ARM_REPS   = 2'd2,
    REG_BODY_RATES = 2'd3
  } reg_e;

  localparam logic [TimeW-1:0] RcTimeoutRst = 32'd500000;
  localparam logic [15:0]      MinSendRst   = 16'd6000;
  localparam logic [CntW-1:0]  ArmRepsRst   = 8'd5;

  typedef struct packed {
    logic [TimeW-1:0] rc_timeout_us;
    logic [15:0]      min_send_interval_us;
    logic [CntW-1:0]  arming_repeats;
    logic             body_rate_en;
  } cfg_t;

  typedef struct packed {
    logic [2:0]       operation;
    logic [TimeW-1:0] now_us;
    logic             rc_kill;
    logic             rc_armed;
    logic             cmd_enable_motors;
  } item_t;

  typedef struct packed {
    st_e              st;
    logic             armed;
    logic             seen_disarmed;
    logic [CntW-1:0]  arm_cnt;
    logic [TimeW-1:0] last_rc;
    logic [TimeW-1:0] last_send;
  } state_t;

  typedef struct packed {
    logic  frame_sent;
    src_e  frame_source;
    arm_e  arm_action;
    logic  throttle_forced_min;
    mode_e mode_action;
    st_e   bridge_state;
    logic  bridge_armed;
  } result_t;

endpackage

// ===== rtl/core/rcafa_if.sv =====
// valid/ready channel interfaces for event items and result items
// depends on rcafa_pkg for widths

interface rcafa_in_if;
  import rcafa_pkg::*;
  logic             valid;
  logic             ready;
  logic [2:0]       operation;
  logic [TimeW-1:0] now_us;
  logic             rc_kill;
  logic             rc_armed;
  logic             cmd_enable_motors;

  modport source (output valid, operation, now_us, rc_kill, rc_armed, cmd_enable_motors,
                  input ready);
  modport sink (input valid, operation, now_us, rc_kill, rc_armed, cmd_enable_motors,
                output ready);
endinterface

interface rcafa_out_if;
  logic       valid;
  logic       ready;
  logic       frame_sent;
  logic [1:0] frame_source;
  logic [1:0] arm_action;
  logic       throttle_forced_min;
  logic [1:0] mode_action;
  logic [2:0] bridge_state;
  logic       bridge_armed;

  modport source (output valid, frame_sent, frame_source, arm_action, throttle_forced_min,
                  mode_action, bridge_state, bridge_armed, input ready);
  modport sink (input valid, frame_sent, frame_source, arm_action, throttle_forced_min,
                mode_action, bridge_state, bridge_armed, output ready);
endinterface

// ===== rtl/core/rcafa_core.sv =====
// next-state and frame decision for one event item
// combinational; depends on rcafa_pkg

module rcafa_core
  import rcafa_pkg::*;
(
  input  state_t  state_i,
  input  cfg_t    cfg_i,
  input  item_t   item_i,
  output state_t  state_o,
  output result_t res_o
);

  logic             emit;
  src_e             src;
  st_e              st;
  logic [TimeW-1:0] rc_gap;
  logic [TimeW-1:0] send_gap;
  logic             rc_stale;
  logic             too_soon;
  arm_e             arm;
  mode_e            mode;
  logic             thr;
  logic             take;

  assign rc_gap   = item_i.now_us - state_i.last_rc;
  assign send_gap = item_i.now_us - state_i.last_send;
  assign rc_stale = rc_gap > cfg_i.rc_timeout_us;
  assign too_soon = send_gap <= {16'd0, cfg_i.min_send_interval_us};

  always_comb begin
    state_o = state_i;
    emit    = 1'b0;
    src     = SRC_NONE;
    case (item_i.operation)
      OP_TICK: begin
        if (state_i.st == ST_RC && rc_stale) begin
          state_o.st = ST_AUTO;
        end
        if (state_o.st == ST_KILL) begin
          emit          = 1'b1;
          src           = SRC_KILL;
          state_o.armed = 1'b0;
        end
      end
      OP_RC: begin
        state_o.last_rc = item_i.now_us;
        if (item_i.rc_kill) begin
          state_o.st = ST_KILL;
        end else if (state_i.st == ST_KILL) begin
          state_o.st = ST_OFF;
        end
        if (state_o.st != ST_KILL) begin
          if (item_i.rc_armed) begin
            if (state_i.seen_disarmed) begin
              state_o.st = ST_RC;
              emit       = 1'b1;
              src        = SRC_RC;
            end
          end else if (state_o.st == ST_RC) begin
            state_o.st = state_i.armed ? ST_AUTO : ST_OFF;
          end else if (!state_i.seen_disarmed) begin
            state_o.seen_disarmed = 1'b1;
          end else if (state_o.st != ST_AUTO) begin
            emit = 1'b1;
            src  = SRC_RC;
          end
        end
      end
      OP_CMD: begin
        if (state_i.armed && state_i.st == ST_AUTO) begin
          if (!item_i.cmd_enable_motors) begin
            state_o.st = ST_OFF;
          end
          emit = 1'b1;
          src  = SRC_CMD;
        end
      end
      OP_ARM:     state_o.armed = 1'b1;
      OP_DISARM:  state_o.armed = 1'b0;
      OP_REQ_ARM: begin
        state_o.st      = ST_ARM;
        state_o.arm_cnt = '0;
      end
      default: ;
    endcase

    st   = state_o.st;
    arm  = ARM_KEEP;
    mode = MODE_KEEP;
    thr  = 1'b0;
    take = 1'b0;
    case (st)
      ST_ARM: begin
        if (state_o.arm_cnt >= cfg_i.arming_repeats) begin
          st = ST_AUTO;
        end else begin
          thr  = 1'b1;
          arm  = ARM_FORCE1;
          take = 1'b1;
        end
      end
      ST_AUTO: begin
        arm  = ARM_FORCE1;
        mode = cfg_i.body_rate_en ? MODE_RATE : MODE_ATT;
      end
      ST_RC:   mode = MODE_ATT;
      default: arm = ARM_FORCE0;
    endcase

    res_o = '0;
    if (emit) begin
      state_o.st = st;
      if (!too_soon) begin
        state_o.last_send = item_i.now_us;
        if (take) begin
          state_o.arm_cnt = state_o.arm_cnt + 8'd1;
        end
        res_o.frame_sent          = 1'b1;
        res_o.frame_source        = src;
        res_o.arm_action          = arm;
        res_o.throttle_forced_min = thr;
        res_o.mode_action         = mode;
      end
    end
    res_o.bridge_state = state_o.st;
    res_o.bridge_armed = state_o.armed;
  end

endmodule

// ===== rtl/core/rc_autonomy_failsafe_arbiter.sv =====
// rc / autonomy failsafe arbiter top level: input register, decision logic, result register
// an accepted item waits in the input register, its result in the result register
// throughput: one item per cycle while the output is ready; the core is combinational
// reset: bridge in kill, disarmed, counters and timestamps zero, registers at defaults
// depends on rcafa_pkg, rcafa_if and rcafa_core

module rc_autonomy_failsafe_arbiter
  import rcafa_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  rcafa_in_if.sink          in_i,
  rcafa_out_if.source       out_o,
  input  logic              cfg_we_i,
  input  logic [IdxW-1:0]   cfg_idx_i,
  input  logic [CfgW-1:0]   cfg_data_i
);

  cfg_t    cfg_q, cfg_d;
  state_t  state_q, state_d;
  item_t   item_q;
  logic    item_vld_q;
  result_t res_q, res_d;
  logic    res_vld_q;
  logic    advance;
  logic    fire;
  logic    in_acc;

  assign advance   = !res_vld_q || out_o.ready;
  assign fire      = item_vld_q && advance;
  assign in_i.ready = !item_vld_q || advance;
  assign in_acc    = in_i.valid && in_i.ready;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_RC_TIMEOUT: cfg_d.rc_timeout_us        = cfg_data_i;
        REG_MIN_SEND:   cfg_d.min_send_interval_us = cfg_data_i[15:0];
        REG_ARM_REPS:   cfg_d.arming_repeats       = cfg_data_i[CntW-1:0];
        REG_BODY_RATES: cfg_d.body_rate_en         = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  rcafa_core u_core (
    .state_i (state_q),
    .cfg_i   (cfg_q),
    .item_i  (item_q),
    .state_o (state_d),
    .res_o   (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rc_timeout_us        <= RcTimeoutRst;
      cfg_q.min_send_interval_us <= MinSendRst;
      cfg_q.arming_repeats       <= ArmRepsRst;
      cfg_q.body_rate_en         <= 1'b0;
      state_q.st                 <= ST_KILL;
      state_q.armed              <= 1'b0;
      state_q.seen_disarmed      <= 1'b0;
      state_q.arm_cnt            <= '0;
      state_q.last_rc            <= '0;
      state_q.last_send          <= '0;
      item_vld_q                 <= 1'b0;
      res_vld_q                  <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
      if (in_acc) begin
        item_vld_q <= 1'b1;
      end else if (advance) begin
        item_vld_q <= 1'b0;
      end
      if (fire) begin
        state_q   <= state_d;
        res_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        res_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      item_q.operation         <= in_i.operation;
      item_q.now_us            <= in_i.now_us;
      item_q.rc_kill           <= in_i.rc_kill;
      item_q.rc_armed          <= in_i.rc_armed;
      item_q.cmd_enable_motors <= in_i.cmd_enable_motors;
    end
    if (fire) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid               = res_vld_q;
  assign out_o.frame_sent          = res_q.frame_sent;
  assign out_o.frame_source        = res_q.frame_source;
  assign out_o.arm_action          = res_q.arm_action;
  assign out_o.throttle_forced_min = res_q.throttle_forced_min;
  assign out_o.mode_action         = res_q.mode_action;
  assign out_o.bridge_state        = res_q.bridge_state;
  assign out_o.bridge_armed        = res_q.bridge_armed;

endmodule
